>>> hw/rtl/ppm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppm_pkg;
   localparam int CFG_WIDTH = 13;
   localparam int NUM_LANES = 4;
   localparam int LEVEL_WIDTH = 16;
   localparam int DAC_WIDTH = 12;
   localparam int CFG_INDEX_WIDTH = 3;

   localparam logic [CFG_INDEX_WIDTH-1:0] REG_APPS_MIN     = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_APPS_MAX     = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRAKE_MIN    = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRAKE_MAX    = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_AGREE_LIMIT  = 3'd4;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_APPS_LATCH   = 3'd5;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRAKE_LATCH  = 3'd6;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_APPS_REST    = 3'd7;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] agreement_limit;
      logic [CFG_WIDTH-1:0] apps_latch_level;
      logic [CFG_WIDTH-1:0] brake_latch_level;
      logic [CFG_WIDTH-1:0] apps_rest_level;
      logic                 apps_bad_cal;
      logic                 brake_bad_cal;
   } merge_cfg_type;
endpackage
`default_nettype wire

>>> hw/rtl/ppm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// one normalising lane: restoring division, one quotient bit per cycle
module ppm_lane #(
   parameter int ADC_WIDTH = 12,
   parameter int FRAC_BITS = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ADC_WIDTH-1:0]              raw,
   input  wire logic [ppm_pkg::CFG_WIDTH-1:0]     lo,
   input  wire logic [ppm_pkg::CFG_WIDTH-1:0]     hi,
   output logic                                   done,
   output logic signed [ppm_pkg::LEVEL_WIDTH-1:0] level
);
   localparam int CW = ppm_pkg::CFG_WIDTH;
   localparam int MW = (ADC_WIDTH > CW ? ADC_WIDTH : CW) + 1;
   localparam int NW = MW + FRAC_BITS;
   localparam int SW = CW + 1;
   localparam int CNT_W = $clog2(NW + 1);
   localparam int LW = ppm_pkg::LEVEL_WIDTH;

   logic [NW-1:0]    quo_ff, quo_in;
   logic [SW:0]      rem_ff, rem_in;
   logic [CW-1:0]    span_ff, span_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic signed [MW:0] diff;
   logic [MW-1:0]      mag;
   logic [SW:0]        trial;
   logic [NW-1:0]      q_neg;
   logic signed [NW:0] q_signed;

   always_comb begin
      diff = $signed({1'b0, {(MW - ADC_WIDTH){1'b0}}, raw})
           - $signed({1'b0, {(MW - CW){1'b0}}, lo});
      mag = diff[MW] ? MW'(-diff) : diff[MW-1:0];
      trial = {rem_ff[SW-1:0], quo_ff[NW-1]};
      quo_in = quo_ff;
      rem_in = rem_ff;
      span_in = span_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = {mag, {FRAC_BITS{1'b0}}};
         rem_in = '0;
         span_in = hi - lo;
         neg_in = diff[MW];
         zero_in = (hi <= lo);
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b00, span_ff}) begin
            rem_in = trial - {2'b00, span_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      span_ff <= span_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      q_neg = -quo_ff;
      q_signed = neg_ff ? $signed({q_neg[NW-1] | (quo_ff != '0), q_neg})
                        : $signed({1'b0, quo_ff});
      if (zero_ff)
         level = '0;
      else if (q_signed > $signed((NW+1)'(32767)))
         level = LW'(32767);
      else if (q_signed < -$signed((NW+1)'(32768)))
         level = {1'b1, {(LW-1){1'b0}}};
      else
         level = q_signed[LW-1:0];
   end
   assign done = done_ff;
endmodule
`default_nettype wire

>>> hw/rtl/ppm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// combines the four lane levels into fault flags and the dac code
module ppm_merge #(
   parameter int FRAC_BITS = 12
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire ppm_pkg::merge_cfg_type                  cfg,
   input  wire logic signed [ppm_pkg::LEVEL_WIDTH-1:0]  apps1,
   input  wire logic signed [ppm_pkg::LEVEL_WIDTH-1:0]  apps2,
   input  wire logic signed [ppm_pkg::LEVEL_WIDTH-1:0]  front,
   input  wire logic signed [ppm_pkg::LEVEL_WIDTH-1:0]  rear,
   output logic                                         done,
   output logic [ppm_pkg::DAC_WIDTH-1:0]                throttle_code,
   output logic                                         throttle_enable,
   output logic signed [ppm_pkg::LEVEL_WIDTH-1:0]       apps1_level,
   output logic                                         agreement_fault,
   output logic                                         latch_fault,
   output logic                                         range_fault,
   output logic                                         range_fault_sticky
);
   localparam int LW = ppm_pkg::LEVEL_WIDTH;
   localparam int PW = LW + 2 + FRAC_BITS + 1;
   localparam longint ONE_Q = longint'(1) << FRAC_BITS;
   localparam longint RANGE_LO = -((ONE_Q + 5) / 10);
   localparam longint RANGE_HI = (11 * ONE_Q + 5) / 10;
   localparam int DW = ppm_pkg::DAC_WIDTH;

   // stage one: products registered, stage two: compare and latch
   logic signed [PW-1:0] lhs_ff, rhs_ff;
   logic                 ne_ff, range_ff, step_ff;
   logic signed [LW:0]   d;
   logic signed [LW:0]   s;
   logic                 oor;
   logic                 latch_ff, latch_in;
   logic                 seen_ff;
   logic                 agree;
   logic signed [LW-1:0] front_ff;
   logic [DW-1:0]        code;

   function automatic logic out_of_range(input logic signed [LW-1:0] v);
      out_of_range = ($signed(32'(v)) <= 32'(RANGE_LO)) || ($signed(32'(v)) >= 32'(RANGE_HI));
   endfunction

   always_comb begin
      d = (apps1 > apps2) ? (LW+1)'(apps1) - (LW+1)'(apps2) : (LW+1)'(apps2) - (LW+1)'(apps1);
      s = (LW+1)'(apps1) + (LW+1)'(apps2);
      oor = cfg.apps_bad_cal | cfg.brake_bad_cal | out_of_range(apps1)
          | out_of_range(apps2) | out_of_range(front) | out_of_range(rear);
   end

   always_ff @(posedge clock) begin
      lhs_ff <= PW'(d) <<< (FRAC_BITS + 1);
      rhs_ff <= $signed({1'b0, cfg.agreement_limit}) * PW'(s);
      ne_ff <= apps1 != apps2;
      range_ff <= oor;
      apps1_level <= apps1;
      if (reset) step_ff <= 1'b0;
      else step_ff <= start;
   end

   always_comb begin
      agree = ne_ff && (lhs_ff >= rhs_ff);
      latch_in = latch_ff;
      if ((apps1_level > $signed({4'b0, cfg.apps_latch_level}))
          && (front_ff > $signed({4'b0, cfg.brake_latch_level})))
         latch_in = 1'b1;
      else if (latch_ff && (apps1_level < $signed({4'b0, cfg.apps_rest_level})))
         latch_in = 1'b0;
   end

   always_ff @(posedge clock) front_ff <= front;

   always_comb begin
      if (apps1_level < 0) code = '0;
      else if (apps1_level > $signed(LW'(4095))) code = {DW{1'b1}};
      else code = apps1_level[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 1'b0;
         seen_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         done <= step_ff;
         if (step_ff) begin
            latch_ff <= latch_in;
            seen_ff <= seen_ff | range_ff;
         end
      end
      if (step_ff) begin
         agreement_fault <= agree;
         range_fault <= range_ff;
         throttle_enable <= !(range_ff || agree || latch_in);
         throttle_code <= (range_ff || agree || latch_in) ? '0 : code;
      end
   end
   assign latch_fault = latch_ff;
   assign range_fault_sticky = seen_ff;
endmodule
`default_nettype wire

>>> hw/rtl/pedal_plausibility_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// a req word runs through the bit-serial divider in each lane, then the two merge stages,
// and the result is registered into the rsp word
// one req word at a time: the next req word waits until the rsp word has been taken
// reset: synchronous, restores calibration defaults and clears latch and sticky flag
module pedal_plausibility_monitor #(
   parameter int ADC_WIDTH = 12,
   parameter int FRAC_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // apps1_raw, apps2_raw, front_brake_raw, rear_brake_raw
   input  wire logic [((4*ADC_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // throttle_code, throttle_enable, apps1_level, agreement_fault, latch_fault,
   // range_fault, range_fault_sticky
   output logic [39:0]               rsp_tdata,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [2:0]           csr_index,
   input  wire logic [12:0]          csr_data
);
   localparam int CW = ppm_pkg::CFG_WIDTH;
   localparam int LW = ppm_pkg::LEVEL_WIDTH;

   logic [CW-1:0] cfg_ff [8];
   logic busy_ff;
   logic rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic start;
   logic [3:0] lane_done;
   logic signed [LW-1:0] lvl [4];
   logic merge_done;
   ppm_pkg::merge_cfg_type mcfg;
   logic [11:0] t_code;
   logic t_en, a_f, l_f, r_f, r_s;
   logic signed [LW-1:0] a_lvl;

   assign req_tready = !busy_ff && !rsp_valid_ff;
   assign start = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[ppm_pkg::REG_APPS_MIN] <= 13'd1241;
         cfg_ff[ppm_pkg::REG_APPS_MAX] <= 13'd2482;
         cfg_ff[ppm_pkg::REG_BRAKE_MIN] <= 13'd0;
         cfg_ff[ppm_pkg::REG_BRAKE_MAX] <= 13'd4096;
         cfg_ff[ppm_pkg::REG_AGREE_LIMIT] <= 13'd819;
         cfg_ff[ppm_pkg::REG_APPS_LATCH] <= 13'd1638;
         cfg_ff[ppm_pkg::REG_BRAKE_LATCH] <= 13'd410;
         cfg_ff[ppm_pkg::REG_APPS_REST] <= 13'd1229;
      end else if (csr_valid) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   genvar g;
   for (g = 0; g < 4; g++) begin : g_lane
      ppm_lane #(.ADC_WIDTH(ADC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .reset(reset), .start(start),
         .raw(req_tdata[g*ADC_WIDTH +: ADC_WIDTH]),
         .lo(g < 2 ? cfg_ff[ppm_pkg::REG_APPS_MIN] : cfg_ff[ppm_pkg::REG_BRAKE_MIN]),
         .hi(g < 2 ? cfg_ff[ppm_pkg::REG_APPS_MAX] : cfg_ff[ppm_pkg::REG_BRAKE_MAX]),
         .done(lane_done[g]), .level(lvl[g]));
   end

   always_comb begin
      mcfg.agreement_limit = cfg_ff[ppm_pkg::REG_AGREE_LIMIT];
      mcfg.apps_latch_level = cfg_ff[ppm_pkg::REG_APPS_LATCH];
      mcfg.brake_latch_level = cfg_ff[ppm_pkg::REG_BRAKE_LATCH];
      mcfg.apps_rest_level = cfg_ff[ppm_pkg::REG_APPS_REST];
      mcfg.apps_bad_cal = cfg_ff[ppm_pkg::REG_APPS_MAX] <= cfg_ff[ppm_pkg::REG_APPS_MIN];
      mcfg.brake_bad_cal = cfg_ff[ppm_pkg::REG_BRAKE_MAX] <= cfg_ff[ppm_pkg::REG_BRAKE_MIN];
   end

   ppm_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock(clock), .reset(reset), .start(&lane_done), .cfg(mcfg),
      .apps1(lvl[0]), .apps2(lvl[1]), .front(lvl[2]), .rear(lvl[3]),
      .done(merge_done), .throttle_code(t_code), .throttle_enable(t_en),
      .apps1_level(a_lvl), .agreement_fault(a_f), .latch_fault(l_f),
      .range_fault(r_f), .range_fault_sticky(r_s));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) busy_ff <= 1'b1;
         else if (merge_done) busy_ff <= 1'b0;
         if (merge_done) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (merge_done)
         rsp_data_ff <= {7'd0, r_s, r_f, l_f, a_f, a_lvl, t_en, t_code};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
endmodule
`default_nettype wire

>>> hw/rtl/ppm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ppm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   // no new word while a result is pending
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept during pending rsp");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped");
   // disabled throttle gives zero code
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[12] |-> rsp_tdata[11:0] == 12'd0)
      else $error("code while disabled");
   a_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31] |-> rsp_tdata[32]) else $error("sticky lost");
endmodule
bind pedal_plausibility_monitor ppm_checker u_ppm_checker (.*);
`default_nettype wire
